### design/kstp_pkg.sv
// Shared types, constants and the Kelvin term table of the symmetric tensor product.
package kstp_pkg;

	localparam int COMP_W   = 32;
	localparam int PROD_W   = 64;
	localparam int SUM_W    = 65;
	localparam int ACC_W    = 98;
	localparam int ENTRY_W  = 64;
	localparam int SPLIT    = 32;
	localparam int SAT_MSB  = SPLIT + ENTRY_W - 1;
	localparam int NUM_COMP = 6;
	localparam int ROW_W    = 3;
	localparam int IDX_W    = 3;
	localparam int DIM_W    = 2;
	localparam int QDEPTH   = 2;
	localparam int QPTR_W   = 1;

	localparam logic [DIM_W-1:0] DIM_PLANE = 2'd2;
	localparam logic [DIM_W-1:0] DIM_RESET = 2'd3;

	localparam logic [ROW_W-1:0] LAST_ROW_3D    = 3'd5;
	localparam logic [ROW_W-1:0] LAST_ROW_PLANE = 3'd3;

	localparam logic [COMP_W-1:0]  W_ROOT     = 32'd1518500250;
	localparam logic [ACC_W-1:0]   ROUND_HALF = {{(ACC_W-SPLIT){1'b0}}, 32'h8000_0000};
	localparam logic [ENTRY_W-1:0] ENTRY_MAX  = {1'b0, {(ENTRY_W-1){1'b1}}};
	localparam logic [ENTRY_W-1:0] ENTRY_MIN  = {1'b1, {(ENTRY_W-1){1'b0}}};

	typedef enum logic [1:0] {
		WT_NONE,
		WT_HALF,
		WT_QUARTER,
		WT_ROOT
	} weight_t;

	typedef struct packed {
		logic [IDX_W-1:0] i;
		logic [IDX_W-1:0] j;
		weight_t          w;
	} term_t;

	typedef struct packed {
		term_t t1;
		term_t t0;
	} term_pair_t;

	typedef struct packed {
		logic [NUM_COMP-1:0][COMP_W-1:0] a;
		logic [NUM_COMP-1:0][COMP_W-1:0] b;
		logic                            plane;
	} kstp_op_t;

	typedef struct packed {
		logic     valid;
		kstp_op_t op;
	} kstp_entry_t;

	function automatic term_t mk(input logic [IDX_W-1:0] i, input logic [IDX_W-1:0] j,
			input weight_t w);
		term_t t;
		t.i = i;
		t.j = j;
		t.w = w;
		return t;
	endfunction

	// cross terms of the upper-triangle entry selected by row and column
	function automatic term_pair_t term_sel(input logic [ROW_W-1:0] r, input logic [ROW_W-1:0] c);
		logic [ROW_W-1:0] lo;
		logic [ROW_W-1:0] hi;
		term_pair_t       tp;
		lo = (r < c) ? r : c;
		hi = (r < c) ? c : r;
		tp.t0 = mk(3'd0, 3'd0, WT_NONE);
		tp.t1 = mk(3'd0, 3'd0, WT_NONE);
		case ({lo, hi})
			6'o00: tp.t0 = mk(3'd0, 3'd0, WT_HALF);
			6'o01: tp.t0 = mk(3'd3, 3'd3, WT_QUARTER);
			6'o02: tp.t0 = mk(3'd5, 3'd5, WT_QUARTER);
			6'o03: tp.t0 = mk(3'd0, 3'd3, WT_HALF);
			6'o04: tp.t0 = mk(3'd3, 3'd5, WT_ROOT);
			6'o05: tp.t0 = mk(3'd0, 3'd5, WT_HALF);
			6'o11: tp.t0 = mk(3'd1, 3'd1, WT_HALF);
			6'o12: tp.t0 = mk(3'd4, 3'd4, WT_QUARTER);
			6'o13: tp.t0 = mk(3'd1, 3'd3, WT_HALF);
			6'o14: tp.t0 = mk(3'd1, 3'd4, WT_HALF);
			6'o15: tp.t0 = mk(3'd3, 3'd4, WT_ROOT);
			6'o22: tp.t0 = mk(3'd2, 3'd2, WT_HALF);
			6'o23: tp.t0 = mk(3'd4, 3'd5, WT_ROOT);
			6'o24: tp.t0 = mk(3'd2, 3'd4, WT_HALF);
			6'o25: tp.t0 = mk(3'd2, 3'd5, WT_HALF);
			6'o33: begin
				tp.t0 = mk(3'd0, 3'd1, WT_HALF);
				tp.t1 = mk(3'd3, 3'd3, WT_QUARTER);
			end
			6'o34: begin
				tp.t0 = mk(3'd3, 3'd4, WT_QUARTER);
				tp.t1 = mk(3'd1, 3'd5, WT_ROOT);
			end
			6'o35: begin
				tp.t0 = mk(3'd3, 3'd5, WT_QUARTER);
				tp.t1 = mk(3'd0, 3'd4, WT_ROOT);
			end
			6'o44: begin
				tp.t0 = mk(3'd1, 3'd2, WT_HALF);
				tp.t1 = mk(3'd4, 3'd4, WT_QUARTER);
			end
			6'o45: begin
				tp.t0 = mk(3'd4, 3'd5, WT_QUARTER);
				tp.t1 = mk(3'd2, 3'd3, WT_ROOT);
			end
			6'o55: begin
				tp.t0 = mk(3'd0, 3'd2, WT_HALF);
				tp.t1 = mk(3'd5, 3'd5, WT_QUARTER);
			end
			default: ;
		endcase
		return tp;
	endfunction

endpackage

### design/kstp_if.sv
// Request and result channel interfaces of the symmetric tensor product.
interface kstp_in_if import kstp_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [COMP_W-1:0] a_xx;
	logic signed [COMP_W-1:0] a_yy;
	logic signed [COMP_W-1:0] a_zz;
	logic signed [COMP_W-1:0] a_xy;
	logic signed [COMP_W-1:0] a_yz;
	logic signed [COMP_W-1:0] a_xz;
	logic signed [COMP_W-1:0] b_xx;
	logic signed [COMP_W-1:0] b_yy;
	logic signed [COMP_W-1:0] b_zz;
	logic signed [COMP_W-1:0] b_xy;
	logic signed [COMP_W-1:0] b_yz;
	logic signed [COMP_W-1:0] b_xz;

	modport source (
		output valid, a_xx, a_yy, a_zz, a_xy, a_yz, a_xz,
		output b_xx, b_yy, b_zz, b_xy, b_yz, b_xz,
		input  ready
	);
	modport sink (
		input  valid, a_xx, a_yy, a_zz, a_xy, a_yz, a_xz,
		input  b_xx, b_yy, b_zz, b_xy, b_yz, b_xz,
		output ready
	);
endinterface

interface kstp_out_if import kstp_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [ROW_W-1:0]          row_index;
	logic signed [ENTRY_W-1:0] entry_0;
	logic signed [ENTRY_W-1:0] entry_1;
	logic signed [ENTRY_W-1:0] entry_2;
	logic signed [ENTRY_W-1:0] entry_3;
	logic signed [ENTRY_W-1:0] entry_4;
	logic signed [ENTRY_W-1:0] entry_5;
	logic                      last_row;

	modport source (
		output valid, row_index, entry_0, entry_1, entry_2, entry_3, entry_4, entry_5,
		output last_row,
		input  ready
	);
	modport sink (
		input  valid, row_index, entry_0, entry_1, entry_2, entry_3, entry_4, entry_5,
		input  last_row,
		output ready
	);
endinterface

### design/kstp_front.sv
// Front end: request register, dimension register and plane classification.
module kstp_front import kstp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	kstp_in_if.sink          operands,
	input  logic             cfg_we,
	input  logic [DIM_W-1:0] cfg_data,
	output kstp_entry_t      push,
	input  logic             push_ready
);

	logic [DIM_W-1:0] dimension_q;
	logic             fr_valid_q;
	kstp_op_t         fr_op_q;
	kstp_op_t         op_d;
	logic             accept;

	always_comb begin
		operands.ready = !fr_valid_q || push_ready;
	end

	assign accept = operands.valid && operands.ready;

	// drop yz and xz in plane mode
	always_comb begin
		op_d.plane = (dimension_q == DIM_PLANE);
		op_d.a[0]  = operands.a_xx;
		op_d.a[1]  = operands.a_yy;
		op_d.a[2]  = operands.a_zz;
		op_d.a[3]  = operands.a_xy;
		op_d.a[4]  = op_d.plane ? '0 : operands.a_yz;
		op_d.a[5]  = op_d.plane ? '0 : operands.a_xz;
		op_d.b[0]  = operands.b_xx;
		op_d.b[1]  = operands.b_yy;
		op_d.b[2]  = operands.b_zz;
		op_d.b[3]  = operands.b_xy;
		op_d.b[4]  = op_d.plane ? '0 : operands.b_yz;
		op_d.b[5]  = op_d.plane ? '0 : operands.b_xz;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dimension_q <= DIM_RESET;
			fr_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				dimension_q <= cfg_data;
			end
			if (accept) begin
				fr_valid_q <= 1'b1;
			end else if (push_ready) begin
				fr_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fr_op_q <= op_d;
		end
	end

	always_comb begin
		push.valid = fr_valid_q;
		push.op    = fr_op_q;
	end

endmodule

### design/kstp_queue.sv
// Two-entry queue between the front end and the row engine.
module kstp_queue import kstp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  kstp_entry_t push,
	output logic        push_ready,
	output kstp_entry_t head,
	input  logic        pop
);

	kstp_op_t          mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (count_q != (QPTR_W+1)'(QDEPTH));
	assign do_push    = push.valid && push_ready;
	assign do_pop     = pop && (count_q != '0);

	always_comb begin
		head.valid = (count_q != '0);
		head.op    = mem_q[rd_ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.op;
		end
	end

endmodule

### design/kstp_back.sv
// Row engine: row sequencer, six-lane product pipeline and result register.
module kstp_back import kstp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  kstp_entry_t head,
	output logic        pop,
	kstp_out_if.source  rows
);

	logic             adv;
	logic             iss;
	logic             last_issue;
	logic [ROW_W-1:0] row_q;
	logic [ROW_W-1:0] last_idx;

	logic             v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [ROW_W-1:0] row_s1, row_s2, row_s3, row_s4, row_s5;
	logic             last_s1, last_s2, last_s3, last_s4, last_s5;

	logic                      out_valid_q;
	logic [ROW_W-1:0]          out_row_q;
	logic                      out_last_q;
	logic signed [ENTRY_W-1:0] out_entry_q [NUM_COMP];
	logic signed [ENTRY_W-1:0] entry_sat [NUM_COMP];

	assign adv        = !out_valid_q || rows.ready;
	assign last_idx   = head.op.plane ? LAST_ROW_PLANE : LAST_ROW_3D;
	assign iss        = head.valid && adv;
	assign last_issue = (row_q == last_idx);
	assign pop        = iss && last_issue;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q       <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (iss) begin
				row_q <= last_issue ? '0 : row_q + 1'b1;
			end
			if (adv) begin
				v_s1        <= iss;
				v_s2        <= v_s1;
				v_s3        <= v_s2;
				v_s4        <= v_s3;
				v_s5        <= v_s4;
				out_valid_q <= v_s5;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			row_s1     <= row_q;
			row_s2     <= row_s1;
			row_s3     <= row_s2;
			row_s4     <= row_s3;
			row_s5     <= row_s4;
			out_row_q  <= row_s5;
			last_s1    <= last_issue;
			last_s2    <= last_s1;
			last_s3    <= last_s2;
			last_s4    <= last_s3;
			last_s5    <= last_s4;
			out_last_q <= last_s5;
			for (int c = 0; c < NUM_COMP; c++) begin
				out_entry_q[c] <= entry_sat[c];
			end
		end
	end

	for (genvar c = 0; c < NUM_COMP; c++) begin : g_lane
		term_pair_t                tp;
		term_t                     tm [2];
		logic signed [PROD_W-1:0]  p1_s1 [2];
		logic signed [PROD_W-1:0]  p2_s1 [2];
		weight_t                   w_s1 [2];
		weight_t                   w_s2 [2];
		logic signed [SUM_W-1:0]   s_s2 [2];
		logic [PROD_W-1:0]         lo_s3 [2];
		logic signed [SUM_W-1:0]   hi_s3 [2];
		logic signed [ACC_W-1:0]   t_s4 [2];
		logic signed [ACC_W-1:0]   acc_s5;
		logic                      in_range;

		always_comb begin
			tp    = term_sel(row_q, ROW_W'(c));
			tm[0] = tp.t0;
			tm[1] = tp.t1;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				for (int t = 0; t < 2; t++) begin
					p1_s1[t] <= $signed(head.op.a[tm[t].i]) * $signed(head.op.b[tm[t].j]);
					p2_s1[t] <= $signed(head.op.a[tm[t].j]) * $signed(head.op.b[tm[t].i]);
					w_s1[t]  <= tm[t].w;

					s_s2[t] <= SUM_W'(p1_s1[t]) + SUM_W'(p2_s1[t]);
					w_s2[t] <= w_s1[t];

					case (w_s2[t])
						WT_ROOT: begin
							lo_s3[t] <= PROD_W'(s_s2[t][SPLIT-1:0]) * PROD_W'(W_ROOT);
							hi_s3[t] <= SUM_W'($signed(s_s2[t][SUM_W-1:SPLIT]))
								* $signed(SUM_W'(W_ROOT));
						end
						WT_HALF: begin
							lo_s3[t] <= PROD_W'(s_s2[t][SPLIT-1:0]) << 31;
							hi_s3[t] <= SUM_W'($signed(s_s2[t][SUM_W-1:SPLIT])) <<< 31;
						end
						WT_QUARTER: begin
							lo_s3[t] <= PROD_W'(s_s2[t][SPLIT-1:0]) << 30;
							hi_s3[t] <= SUM_W'($signed(s_s2[t][SUM_W-1:SPLIT])) <<< 30;
						end
						default: begin
							lo_s3[t] <= '0;
							hi_s3[t] <= '0;
						end
					endcase

					t_s4[t] <= (ACC_W'(hi_s3[t]) << SPLIT) + ACC_W'(lo_s3[t]);
				end
				acc_s5 <= t_s4[0] + t_s4[1] + ROUND_HALF;
			end
		end

		assign in_range = (acc_s5[ACC_W-1:SAT_MSB] == '0) || (acc_s5[ACC_W-1:SAT_MSB] == '1);
		assign entry_sat[c] = in_range ? acc_s5[SAT_MSB:SPLIT]
			: (acc_s5[ACC_W-1] ? ENTRY_MIN : ENTRY_MAX);
	end

	always_comb begin
		rows.valid     = out_valid_q;
		rows.row_index = out_row_q;
		rows.entry_0   = out_entry_q[0];
		rows.entry_1   = out_entry_q[1];
		rows.entry_2   = out_entry_q[2];
		rows.entry_3   = out_entry_q[3];
		rows.entry_4   = out_entry_q[4];
		rows.entry_5   = out_entry_q[5];
		rows.last_row  = out_last_q;
	end

`ifndef SYNTHESIS
	a_row_step: assert property (@(posedge clk) disable iff (!arst_n)
		iss && !last_issue |=> row_q == $past(row_q) + 3'd1)
		else $error("row counter did not advance by one");

	a_plane_rows: assert property (@(posedge clk) disable iff (!arst_n)
		head.valid && head.op.plane |-> row_q <= LAST_ROW_PLANE)
		else $error("plane request issued beyond its last row");

	a_plane_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_last_q && out_row_q == LAST_ROW_PLANE
		|-> out_entry_q[4] == '0 && out_entry_q[5] == '0)
		else $error("plane result row carries nonzero 3D columns");
`endif

endmodule

### design/kelvin_symmetric_tensor_product.sv
// Top level of the symmetrized Kelvin tensor product engine.
//
//   channel    dir  handshake    payload
//   operands   in   valid/ready  a_xx..a_xz, b_xx..b_xz (signed 32)
//   rows       out  valid/ready  row_index, entry_0..entry_5 (signed 64), last_row
//   cfg        in   cfg_we       cfg_data: dimension (2 selects plane, else 3D)
//
// One row leaves per cycle while the rows channel is ready: a 3D request yields 6 rows, a plane request 4,
// set by the row sequencer issuing one row a cycle into the six-lane pipeline.
// First row passes the front register, the queue, stages s1 to s5 and the result register; two requests queue.
// Reset clears all valid state and sets dimension to 3D.
// A stalled rows channel freezes the row pipeline; the front keeps taking requests
// until the queue and the front register are full.
module kelvin_symmetric_tensor_product import kstp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	kstp_in_if.sink          operands,
	kstp_out_if.source       rows,
	input  logic             cfg_we,
	input  logic [DIM_W-1:0] cfg_data
);

	kstp_entry_t push;
	kstp_entry_t head;
	logic        push_ready;
	logic        pop;

	kstp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.operands   (operands),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.push       (push),
		.push_ready (push_ready)
	);

	kstp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.head       (head),
		.pop        (pop)
	);

	kstp_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.rows   (rows)
	);

endmodule

### test/testbench.sv
// Self-checking testbench for the Kelvin symmetric tensor product: random and directed requests.
module testbench;
	import kstp_pkg::*;

	typedef enum logic [1:0] {
		COUPLE_HALF,
		COUPLE_QUARTER,
		COUPLE_ROOT
	} coupling_t;

	typedef struct packed {
		logic [2:0] r;
		logic [2:0] c;
		logic [2:0] i;
		logic [2:0] j;
		coupling_t  w;
	} kterm_t;

	typedef struct packed {
		logic [5:0][31:0] a;
		logic [5:0][31:0] b;
	} tensor_pair_t;

	typedef struct packed {
		logic [2:0]       idx;
		logic [5:0][63:0] e;
		logic             last;
	} matrix_row_t;

	localparam int NUM_TERMS   = 27;
	localparam int ROWS_3D     = 6;
	localparam int ROWS_PLANE  = 4;
	localparam int IDLE_PCT    = 37;
	localparam int PHASE_ITEMS = 25;

	localparam logic signed [127:0] ROUND_BIAS = 128'sd2147483648;
	localparam logic signed [127:0] SAT_HI     = 128'sh7fff_ffff_ffff_ffff;
	localparam logic signed [127:0] SAT_LO     = -SAT_HI - 128'sd1;

	localparam logic [31:0] COMP_MAX = 32'h7fff_ffff;
	localparam logic [31:0] COMP_MIN = 32'h8000_0000;
	localparam logic [31:0] Q_ONE    = 32'h0001_0000;

	localparam kterm_t KELVIN_TERMS [NUM_TERMS] = '{
		'{3'd0, 3'd0, 3'd0, 3'd0, COUPLE_HALF},
		'{3'd0, 3'd1, 3'd3, 3'd3, COUPLE_QUARTER},
		'{3'd0, 3'd2, 3'd5, 3'd5, COUPLE_QUARTER},
		'{3'd0, 3'd3, 3'd0, 3'd3, COUPLE_HALF},
		'{3'd0, 3'd4, 3'd3, 3'd5, COUPLE_ROOT},
		'{3'd0, 3'd5, 3'd0, 3'd5, COUPLE_HALF},
		'{3'd1, 3'd1, 3'd1, 3'd1, COUPLE_HALF},
		'{3'd1, 3'd2, 3'd4, 3'd4, COUPLE_QUARTER},
		'{3'd1, 3'd3, 3'd1, 3'd3, COUPLE_HALF},
		'{3'd1, 3'd4, 3'd1, 3'd4, COUPLE_HALF},
		'{3'd1, 3'd5, 3'd3, 3'd4, COUPLE_ROOT},
		'{3'd2, 3'd2, 3'd2, 3'd2, COUPLE_HALF},
		'{3'd2, 3'd3, 3'd4, 3'd5, COUPLE_ROOT},
		'{3'd2, 3'd4, 3'd2, 3'd4, COUPLE_HALF},
		'{3'd2, 3'd5, 3'd2, 3'd5, COUPLE_HALF},
		'{3'd3, 3'd3, 3'd0, 3'd1, COUPLE_HALF},
		'{3'd3, 3'd3, 3'd3, 3'd3, COUPLE_QUARTER},
		'{3'd3, 3'd4, 3'd3, 3'd4, COUPLE_QUARTER},
		'{3'd3, 3'd4, 3'd1, 3'd5, COUPLE_ROOT},
		'{3'd3, 3'd5, 3'd3, 3'd5, COUPLE_QUARTER},
		'{3'd3, 3'd5, 3'd0, 3'd4, COUPLE_ROOT},
		'{3'd4, 3'd4, 3'd1, 3'd2, COUPLE_HALF},
		'{3'd4, 3'd4, 3'd4, 3'd4, COUPLE_QUARTER},
		'{3'd4, 3'd5, 3'd4, 3'd5, COUPLE_QUARTER},
		'{3'd4, 3'd5, 3'd2, 3'd3, COUPLE_ROOT},
		'{3'd5, 3'd5, 3'd0, 3'd2, COUPLE_HALF},
		'{3'd5, 3'd5, 3'd5, 3'd5, COUPLE_QUARTER}
	};

	class kelvin_scoreboard;
		logic [DIM_W-1:0] dimension;
		matrix_row_t      expected_rows[$];
		int               errors;

		function new();
			dimension = DIM_RESET;
			errors = 0;
		endfunction

		function int pending();
			return expected_rows.size();
		endfunction

		function logic signed [127:0] coupling_value(input coupling_t w);
			case (w)
				COUPLE_HALF:    return 128'sd2147483648;
				COUPLE_QUARTER: return 128'sd1073741824;
				default:        return 128'sd1518500250;
			endcase
		endfunction

		function logic [63:0] round_saturate(input logic signed [127:0] v);
			logic signed [127:0] q;
			q = (v + ROUND_BIAS) >>> 32;
			if (q > SAT_HI)
				return SAT_HI[63:0];
			if (q < SAT_LO)
				return SAT_LO[63:0];
			return q[63:0];
		endfunction

		function void note_request(input tensor_pair_t p);
			logic signed [127:0] av [6];
			logic signed [127:0] bv [6];
			logic signed [127:0] acc [6][6];
			logic signed [127:0] pair_sum;
			matrix_row_t         mr;
			bit                  plane;
			int                  n_rows;
			kterm_t              t;
			plane = (dimension == DIM_PLANE);
			n_rows = plane ? ROWS_PLANE : ROWS_3D;
			for (int k = 0; k < 6; k++) begin
				av[k] = {{96{p.a[k][31]}}, p.a[k]};
				bv[k] = {{96{p.b[k][31]}}, p.b[k]};
				if (plane && k >= 4) begin
					av[k] = '0;
					bv[k] = '0;
				end
				for (int c = 0; c < 6; c++)
					acc[k][c] = '0;
			end
			for (int n = 0; n < NUM_TERMS; n++) begin
				t = KELVIN_TERMS[n];
				pair_sum = av[t.i] * bv[t.j] + av[t.j] * bv[t.i];
				acc[t.r][t.c] = acc[t.r][t.c] + pair_sum * coupling_value(t.w);
			end
			for (int k = 0; k < n_rows; k++) begin
				mr.idx = k[2:0];
				for (int c = 0; c < 6; c++) begin
					if (plane && c >= 4)
						mr.e[c] = '0;
					else
						mr.e[c] = round_saturate(k <= c ? acc[k][c] : acc[c][k]);
				end
				mr.last = (k == n_rows - 1);
				expected_rows.push_back(mr);
			end
		endfunction

		function void check_row(input matrix_row_t got);
			matrix_row_t want;
			if (expected_rows.size() == 0) begin
				$error("row %0d arrived with nothing expected", got.idx);
				errors++;
				return;
			end
			want = expected_rows.pop_front();
			if (got.idx !== want.idx) begin
				$error("row_index: expected %0d, got %0d", want.idx, got.idx);
				errors++;
			end
			for (int c = 0; c < 6; c++) begin
				if (got.e[c] !== want.e[c]) begin
					$error("entry_%0d: expected %0d, got %0d", c,
						$signed(want.e[c]), $signed(got.e[c]));
					errors++;
				end
			end
			if (got.last !== want.last) begin
				$error("last_row: expected %0d, got %0d", want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [DIM_W-1:0] cfg_data;
	bit               idle_on;

	kstp_in_if  operands ();
	kstp_out_if rows ();

	kelvin_symmetric_tensor_product u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.operands (operands),
		.rows     (rows),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	kelvin_scoreboard sb = new();

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(negedge clk) begin
		rows.ready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		tensor_pair_t req;
		matrix_row_t  res;
		if (arst_n) begin
			if (operands.valid && operands.ready) begin
				req.a = {operands.a_xz, operands.a_yz, operands.a_xy,
					operands.a_zz, operands.a_yy, operands.a_xx};
				req.b = {operands.b_xz, operands.b_yz, operands.b_xy,
					operands.b_zz, operands.b_yy, operands.b_xx};
				sb.note_request(req);
			end
			if (rows.valid && rows.ready) begin
				res.idx = rows.row_index;
				res.e = {rows.entry_5, rows.entry_4, rows.entry_3,
					rows.entry_2, rows.entry_1, rows.entry_0};
				res.last = rows.last_row;
				sb.check_row(res);
			end
		end
	end

	function automatic logic [31:0] random_component();
		case ($urandom_range(4))
			0: begin
				case ($urandom_range(2))
					0: return COMP_MAX;
					1: return COMP_MIN;
					default: return '0;
				endcase
			end
			1: return $urandom_range(32'h001f_ffff) - 32'h0010_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic tensor_pair_t uniform_pair(input logic [31:0] av, input logic [31:0] bv);
		tensor_pair_t p;
		for (int k = 0; k < 6; k++) begin
			p.a[k] = av;
			p.b[k] = bv;
		end
		return p;
	endfunction

	// enter at a falling edge; leave at the falling edge after acceptance with valid still high
	task automatic send_request(input tensor_pair_t p);
		while (idle_on && $urandom_range(99) < IDLE_PCT) begin
			operands.valid <= 1'b0;
			@(negedge clk);
		end
		operands.valid <= 1'b1;
		{operands.a_xz, operands.a_yz, operands.a_xy,
			operands.a_zz, operands.a_yy, operands.a_xx} <= p.a;
		{operands.b_xz, operands.b_yz, operands.b_xy,
			operands.b_zz, operands.b_yy, operands.b_xx} <= p.b;
		do @(posedge clk); while (!operands.ready);
		@(negedge clk);
	endtask

	// drop valid and hold until every expected row is back
	task automatic drain();
		operands.valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	task automatic set_dimension(input logic [DIM_W-1:0] d);
		drain();
		cfg_data <= d;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.dimension = d;
	endtask

	task automatic run_directed();
		tensor_pair_t p;
		send_request(uniform_pair('0, '0));
		send_request(uniform_pair(COMP_MAX, COMP_MAX));
		send_request(uniform_pair(COMP_MIN, COMP_MIN));
		send_request(uniform_pair(COMP_MAX, COMP_MIN));
		send_request(uniform_pair(32'd1, 32'd1));
		send_request(uniform_pair(32'hffff_ffff, 32'd1));
		send_request(uniform_pair(32'h5555_5555, 32'haaaa_aaaa));
		p = uniform_pair('0, '0);
		p.a[3] = Q_ONE;
		p.a[4] = Q_ONE;
		p.a[5] = -Q_ONE;
		p.b[0] = Q_ONE;
		p.b[4] = COMP_MIN;
		p.b[5] = COMP_MAX;
		send_request(p);
	endtask

	initial begin
		tensor_pair_t     p;
		logic [DIM_W-1:0] phase_dims [6];
		phase_dims = '{2'd3, 2'd0, 2'd2, 2'd1, 2'd2, 2'd3};
		idle_on = 1'b1;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		rows.ready = 1'b0;
		operands.valid = 1'b0;
		{operands.a_xz, operands.a_yz, operands.a_xy,
			operands.a_zz, operands.a_yy, operands.a_xx} = '0;
		{operands.b_xz, operands.b_yz, operands.b_xy,
			operands.b_zz, operands.b_yy, operands.b_xx} = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		run_directed();
		set_dimension(DIM_PLANE);
		run_directed();

		for (int ph = 0; ph < 6; ph++) begin
			set_dimension(phase_dims[ph]);
			idle_on = (ph != 4);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 1 && n == PHASE_ITEMS / 2)
					drain();
				for (int k = 0; k < 6; k++) begin
					p.a[k] = random_component();
					p.b[k] = random_component();
				end
				send_request(p);
			end
		end

		idle_on = 1'b1;
		drain();
		repeat (16) @(negedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#400000;
		$display("tb: failure");
		$finish;
	end

endmodule

### files.f
design/kstp_pkg.sv
design/kstp_if.sv
design/kstp_front.sv
design/kstp_queue.sv
design/kstp_back.sv
design/kelvin_symmetric_tensor_product.sv
test/testbench.sv
